// File: hw/rtl/deq_pkg.sv
// deq_pkg: shared types and constants for the double-ended queue core
// command and response beat layouts, action and status codes, cell control
// no dependencies
package deq_pkg;

  localparam int DEPTH  = 1024;
  localparam int WORD_W = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SIZE       = 3'd4,
    ACT_EMPTY      = 3'd5,
    ACT_PEEK_FRONT = 3'd6,
    ACT_PEEK_BACK  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    action_t            action;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] data;
    status_t            status;
  } rsp_t;

  // what every cell of a chain does this cycle
  typedef enum logic [1:0] {
    MODE_HOLD,
    MODE_SHR,   // take left neighbour, cell 0 takes the new word
    MODE_SHL,   // take right neighbour
    MODE_LOAD   // the addressed cell takes the new word
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [IDX_W-1:0]   pos;
    logic [WORD_W-1:0]  value;
  } chain_ctrl_t;

endpackage

// File: hw/rtl/deq_cell.sv
// deq_cell: one word of storage in a shift chain
// shifts either way or loads a new word; depends on deq_pkg
module deq_cell
  import deq_pkg::*;
(
  input  logic              clk,
  input  cell_mode_t        mode,
  input  logic              hit,
  input  logic [WORD_W-1:0] left_word,
  input  logic [WORD_W-1:0] right_word,
  input  logic [WORD_W-1:0] load_word,
  output logic [WORD_W-1:0] word
);

  always_ff @(posedge clk) begin
    unique case (mode)
      MODE_SHR:  word <= left_word;
      MODE_SHL:  word <= right_word;
      MODE_LOAD: if (hit) word <= load_word;
      default:   word <= word;
    endcase
  end

endmodule

// File: hw/rtl/deq_chain.sv
// deq_chain: row of deq_cell instances, one end visible at cell 0
// neighbours hand words along every shift; depends on deq_pkg, deq_cell
module deq_chain
  import deq_pkg::*;
(
  input  logic              clk,
  input  chain_ctrl_t       ctrl,
  output logic [WORD_W-1:0] head
);

  logic [WORD_W-1:0] words [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_word;
    logic [WORD_W-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = ctrl.value;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = words[i];
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .mode       (ctrl.mode),
      .hit        (ctrl.pos == IDX_W'(i)),
      .left_word  (left_word),
      .right_word (right_word),
      .load_word  (ctrl.value),
      .word       (words[i])
    );
  end

  assign head = words[0];

endmodule

// File: hw/rtl/double_ended_queue_core.sv
// double_ended_queue_core: bounded deque of 32-bit signed words
// two shift chains of cells plus a count and a response register
// depends on deq_pkg, deq_chain
//
//   channel | signals                      | direction | beat
//   cmd     | cmd_valid, cmd_ready, cmd    | in        | action + value
//   rsp     | rsp_valid, rsp_ready, rsp    | out       | data + status
//
// one command per cycle while cmd_ready is high: every action finishes in
// the cycle it is accepted, since both ends of the deque sit at cell 0 of a chain
// a response appears in the response register the cycle after acceptance
// pushes with room give no response beat
// cmd_ready drops only while a response waits and rsp_ready is low
// reset clears the count and the response valid; cell contents are left as is
module double_ended_queue_core
  import deq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // front chain holds front..back from cell 0, back chain holds back..front
  // an end pop shifts its own chain; the other chain just loses its tail
  // through the count shrinking
  chain_ctrl_t       front_ctrl;
  chain_ctrl_t       back_ctrl;
  logic [WORD_W-1:0] front_head;
  logic [WORD_W-1:0] back_head;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic cmd_fire;
  logic is_empty;
  logic is_full;
  logic rsp_load;
  rsp_t rsp_next;

  assign cmd_ready = !rsp_valid || rsp_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign is_empty  = (count == '0);
  assign is_full   = (count == CNT_W'(DEPTH));

  always_comb begin
    front_ctrl.mode  = MODE_HOLD;
    front_ctrl.pos   = count[IDX_W-1:0];
    front_ctrl.value = cmd.value;
    back_ctrl.mode   = MODE_HOLD;
    back_ctrl.pos    = count[IDX_W-1:0];
    back_ctrl.value  = cmd.value;
    count_next       = count;
    rsp_load         = 1'b0;
    rsp_next.data    = '0;
    rsp_next.status  = ST_OK;

    if (cmd_fire) begin
      unique case (cmd.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (is_full) begin
            // dropped push
            rsp_load        = 1'b1;
            rsp_next.status = ST_FULL;
          end else begin
            count_next = count + CNT_W'(1);
            if (cmd.action == ACT_PUSH_FRONT) begin
              front_ctrl.mode = MODE_SHR;
              back_ctrl.mode  = MODE_LOAD;
            end else begin
              back_ctrl.mode  = MODE_SHR;
              front_ctrl.mode = MODE_LOAD;
            end
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
          rsp_load = 1'b1;
          if (is_empty) begin
            rsp_next.data   = '1;
            rsp_next.status = ST_EMPTY;
          end else begin
            if (cmd.action == ACT_POP_FRONT || cmd.action == ACT_PEEK_FRONT) begin
              rsp_next.data = front_head;
            end else begin
              rsp_next.data = back_head;
            end
            if (cmd.action == ACT_POP_FRONT) begin
              front_ctrl.mode = MODE_SHL;
              count_next      = count - CNT_W'(1);
            end else if (cmd.action == ACT_POP_BACK) begin
              back_ctrl.mode = MODE_SHL;
              count_next     = count - CNT_W'(1);
            end
          end
        end
        ACT_SIZE: begin
          rsp_load      = 1'b1;
          rsp_next.data = WORD_W'(count);
        end
        default: begin
          // emptiness query
          rsp_load      = 1'b1;
          rsp_next.data = is_empty ? WORD_W'(1) : '0;
        end
      endcase
    end
  end

  deq_chain u_front (
    .clk  (clk),
    .ctrl (front_ctrl),
    .head (front_head)
  );

  deq_chain u_back (
    .clk  (clk),
    .ctrl (back_ctrl),
    .head (back_head)
  );

  // count and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // occupancy stays within the store
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("deque count beyond depth");

  // a push with room grows the count by one
  a_push_grow : assert property (@(posedge clk) disable iff (rst)
    cmd_fire && !is_full &&
    (cmd.action == ACT_PUSH_FRONT || cmd.action == ACT_PUSH_BACK)
    |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow count");

  // with one element both chains show the same word
  a_single_same : assert property (@(posedge clk) disable iff (rst)
    count == CNT_W'(1) |-> front_head == back_head)
    else $error("chains disagree on single element");

  // a pop on an empty deque answers minus one with empty status
  a_empty_pop : assert property (@(posedge clk) disable iff (rst)
    cmd_fire && is_empty &&
    (cmd.action == ACT_POP_FRONT || cmd.action == ACT_POP_BACK)
    |=> rsp_valid && rsp.status == ST_EMPTY && rsp.data == '1)
    else $error("empty pop answered wrongly");

endmodule

// File: verif/tb_double_ended_queue_core.sv
// tb_double_ended_queue_core: self-checking bench for the deque core
// a shadow deque predicts every response, random stalls on both channels
// depends on deq_pkg and double_ended_queue_core
module tb_double_ended_queue_core
  import deq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // generous cap, many times the slowest legal run of ~1150 commands
  localparam int unsigned RUN_LIMIT = 1_200_000;

  // shadow deque plus the list of responses still owed by the core
  class deque_ledger;
    logic [31:0] mirror_words [DEPTH];
    int unsigned mirror_head;
    int unsigned mirror_count;
    rsp_t        owed_replies [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned peak;
    int unsigned full_seen;
    int unsigned empty_seen;

    function new();
      mirror_head  = 0;
      mirror_count = 0;
      mismatches   = 0;
      checked      = 0;
      peak         = 0;
      full_seen    = 0;
      empty_seen   = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
      mismatches++;
    endtask

    // apply one accepted command to the shadow deque, note any response it owes
    function void note_command(cmd_t c);
      rsp_t        r;
      bit          answers;
      int unsigned pos;
      answers  = 1'b1;
      r.data   = '0;
      r.status = ST_OK;
      case (c.action)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (mirror_count >= DEPTH) begin
            // full: word dropped, data means nothing but is zero
            r.status = ST_FULL;
          end else begin
            answers = 1'b0;
            if (c.action == ACT_PUSH_FRONT) begin
              mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
              pos = mirror_head;
            end else begin
              pos = (mirror_head + mirror_count) % DEPTH;
            end
            mirror_words[pos] = c.value;
            mirror_count++;
            if (mirror_count > peak) peak = mirror_count;
          end
        end
        ACT_SIZE:  r.data = mirror_count;
        ACT_EMPTY: r.data = (mirror_count == 0) ? 32'sd1 : 32'sd0;
        default: begin
          // pops and peeks
          if (mirror_count == 0) begin
            r.data   = '1;
            r.status = ST_EMPTY;
          end else begin
            if (c.action == ACT_POP_FRONT || c.action == ACT_PEEK_FRONT)
              pos = mirror_head;
            else
              pos = (mirror_head + mirror_count - 1) % DEPTH;
            r.data = mirror_words[pos];
            if (c.action == ACT_POP_FRONT) begin
              mirror_head = (mirror_head + 1) % DEPTH;
              mirror_count--;
            end else if (c.action == ACT_POP_BACK) begin
              mirror_count--;
            end
          end
        end
      endcase
      if (answers) owed_replies = {owed_replies, r};
    endfunction

    task check_response(rsp_t got);
      rsp_t want;
      if (owed_replies.size() == 0) begin
        report_mismatch("unrequested response", got.data, '0);
        return;
      end
      want = owed_replies[0];
      owed_replies.delete(0);
      checked++;
      if (want.status == ST_FULL)  full_seen++;
      if (want.status == ST_EMPTY) empty_seen++;
      if (got.data !== want.data)     report_mismatch("data", got.data, want.data);
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  deque_ledger ledger = new();
  bit          calm   = 1'b0;  // no idling on either side while set
  int unsigned sent   = 0;
  int unsigned cycles = 0;

  always #5 clk = ~clk;

  double_ended_queue_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // extremes show up often so that pops return them too
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // weighted choice: pushes, pops, the rest spread over the queries
  function automatic action_t pick_action(int unsigned push_pct, int unsigned pop_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < push_pct)
      return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
    case ($urandom_range(0, 3))
      0: return ACT_SIZE;
      1: return ACT_EMPTY;
      2: return ACT_PEEK_FRONT;
      default: return ACT_PEEK_BACK;
    endcase
  endfunction

  // present one command beat, hold it until accepted, then maybe idle;
  // valid is left high when no gap follows so back-to-back beats flow
  task automatic send_cmd(action_t a, logic [31:0] v);
    int unsigned gap;
    cmd_valid <= 1'b1;
    cmd       <= '{action: a, value: v};
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sent++;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender backs off until the core has answered everything
  task automatic hold_until_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (ledger.owed_replies.size() != 0) @(posedge clk);
  endtask

  // monitor: both channels sampled at the edge, responses first since a
  // response never belongs to a command accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) ledger.check_response(rsp);
      if (cmd_valid && cmd_ready) ledger.note_command(cmd);
    end
  end

  // response side: bursts of ready broken by random stalls
  initial begin
    int unsigned gap;
    forever begin
      rsp_ready <= 1'b1;
      repeat (1 + $urandom_range(0, 7)) @(posedge clk);
      gap = calm ? 0 : idle_len();
      if (gap != 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("run exceeded %0d cycles, core stopped answering", RUN_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned seg;
    int unsigned push_pct;
    int unsigned pop_pct;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every pop, peek and query on the empty deque after reset
    send_cmd(ACT_POP_FRONT,  rand_value());
    send_cmd(ACT_POP_BACK,   rand_value());
    send_cmd(ACT_PEEK_FRONT, rand_value());
    send_cmd(ACT_PEEK_BACK,  rand_value());
    send_cmd(ACT_SIZE,       rand_value());
    send_cmd(ACT_EMPTY,      rand_value());
    // extremes pushed at both ends, then read back from both ends
    send_cmd(ACT_PUSH_BACK,  32'h7fff_ffff);
    send_cmd(ACT_PUSH_FRONT, 32'h8000_0000);
    send_cmd(ACT_PUSH_BACK,  32'hffff_ffff);
    send_cmd(ACT_PUSH_FRONT, 32'h0000_0000);
    send_cmd(ACT_SIZE,       32'h5555_5555);
    send_cmd(ACT_EMPTY,      32'haaaa_aaaa);
    send_cmd(ACT_PEEK_FRONT, rand_value());
    send_cmd(ACT_PEEK_BACK,  rand_value());
    send_cmd(ACT_POP_BACK,   rand_value());
    send_cmd(ACT_POP_FRONT,  rand_value());
    send_cmd(ACT_POP_FRONT,  rand_value());
    send_cmd(ACT_POP_BACK,   rand_value());
    // emptied again, then a single element pushed at the front and read from the back
    send_cmd(ACT_POP_FRONT,  rand_value());
    send_cmd(ACT_EMPTY,      rand_value());
    send_cmd(ACT_PUSH_FRONT, 32'h5a5a_a5a5);
    send_cmd(ACT_PEEK_BACK,  rand_value());
    send_cmd(ACT_POP_BACK,   rand_value());

    hold_until_drained();

    // fill to the brim from both ends, the odd query mixed in
    while (ledger.mirror_count < DEPTH)
      send_cmd(pick_action(97, 0), rand_value());
    // pushes that must be refused, then queries on the full deque
    repeat (6) send_cmd(pick_action(100, 0), rand_value());
    send_cmd(ACT_SIZE,       rand_value());
    send_cmd(ACT_EMPTY,      rand_value());
    send_cmd(ACT_PEEK_FRONT, rand_value());
    send_cmd(ACT_PEEK_BACK,  rand_value());

    // random segments near the top, each with its own mix
    while (sent < 1100) begin
      seg = $urandom_range(20, 40);
      case ($urandom_range(0, 3))
        0: begin push_pct = 40; pop_pct = 35; end
        1: begin push_pct = 70; pop_pct = 15; end
        2: begin push_pct = 15; pop_pct = 70; end
        default: begin push_pct = 20; pop_pct = 20; end
      endcase
      calm = ($urandom_range(0, 4) == 0);
      repeat (seg) send_cmd(pick_action(push_pct, pop_pct), rand_value());
    end
    calm = 1'b0;

    hold_until_drained();
    repeat (8) @(posedge clk);

    if (ledger.owed_replies.size() != 0)
      $display("%0d responses never arrived", ledger.owed_replies.size());
    $display("%0d commands driven, %0d responses checked", sent, ledger.checked);
    $display("%0d on an empty deque, %0d refused pushes, fill peaked at %0d of %0d",
             ledger.empty_seen, ledger.full_seen, ledger.peak, DEPTH);
    if (ledger.mismatches == 0 && ledger.owed_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
